// ===== rtl/indexed_insert_erase_array_unit_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the indexed insert/erase array unit
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_ERASE_ARRAY_UNIT_ASSERT_SVH
`define INDEXED_INSERT_ERASE_ARRAY_UNIT_ASSERT_SVH

`ifndef SYNTH
// check that is held off while reset is high
`define IIEA_ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that holds at every edge, reset included
`define IIEA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IIEA_ASSERT_DIS(label, clk, rst, prop, msg)
`define IIEA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/iiea_pkg.sv =====
// ----------------------------------------------------------------------------
// iiea_pkg
// operation and status codes and sequencer states of the array unit
// ----------------------------------------------------------------------------
package iiea_pkg;

   localparam int OP_WIDTH     = 3;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_APPEND      = 3'd0,
      OP_INSERT      = 3'd1,
      OP_REMOVE_LAST = 3'd2,
      OP_REMOVE_AT   = 3'd3,
      OP_READ        = 3'd4
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_UP,
      ST_INS_WRITE,
      ST_SHIFT_DOWN,
      ST_READ,
      ST_REPLY
   } state_type;

endpackage

// ===== rtl/iiea_if.sv =====
// ----------------------------------------------------------------------------
// iiea channel interfaces
// valid/ready request and response channels of the array unit
// ----------------------------------------------------------------------------
interface iiea_req_if #(
   parameter int POS_WIDTH  = 5,
   parameter int DATA_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   logic [iiea_pkg::OP_WIDTH-1:0]  operation;
   logic [POS_WIDTH-1:0]           position;
   logic [DATA_WIDTH-1:0]          entry_value;

   modport source (output valid, operation, position, entry_value, input ready);
   modport sink   (input valid, operation, position, entry_value, output ready);
endinterface

interface iiea_rsp_if #(
   parameter int POS_WIDTH  = 5,
   parameter int DATA_WIDTH = 32
);
   logic                              valid;
   logic                              ready;
   logic [iiea_pkg::STATUS_WIDTH-1:0] status;
   logic [POS_WIDTH-1:0]              item_count;
   logic [DATA_WIDTH-1:0]             read_value;

   modport source (output valid, status, item_count, read_value, input ready);
   modport sink   (input valid, status, item_count, read_value, output ready);
endinterface

// ===== rtl/iiea_ram.sv =====
// ----------------------------------------------------------------------------
// iiea_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module iiea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/indexed_insert_erase_array_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_erase_array_unit
// ordered list of entry words in a synchronous ram with a running count
// ----------------------------------------------------------------------------
// usage
//   req carries one transaction per operation: append, insert at position,
//   remove last, remove at position or read. rsp returns one transaction
//   for each: status, count after the operation and the read word.
//   entries live in one ram with a registered read; insert and
//   remove-at move the later entries one place a cycle through that ram,
//   reading one entry while writing back the one fetched the cycle before.
// sequence from accept to reply
//   append, remove last, remove at the last entry, insert at the end, any
//   error and an unknown code go straight to the reply state; read passes
//   through a read state; insert below the end moves the later entries up
//   one by one, then writes the new word; remove at any other position
//   moves the later entries down one by one.
//   the pace is set by the single ram port pair and the reply state.
// reset clears the count and the sequencer; the ram is not cleared, as no
// entry below the count is read before it was written.
// the result sits in an output register: a new request is taken while it
// waits, and the sequencer holds in its reply state until rsp is free.
// ----------------------------------------------------------------------------
`include "indexed_insert_erase_array_unit_assert.svh"

module indexed_insert_erase_array_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   iiea_req_if.sink   req,
   iiea_rsp_if.source rsp
);
   import iiea_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // sequencer and count
   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   status_type      pend_status_ff, pend_status_in;
   logic [DATA_WIDTH-1:0] pend_value_ff, pend_value_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   logic [CW-1:0]   rsp_count_ff, rsp_count_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   // ram port
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [DATA_WIDTH-1:0] ram_rd_data;

   // decode of the request against the current count
   op_type          dec_op;
   status_type      dec_status;
   logic [CW-1:0]   dec_count;
   logic            dec_write;
   logic [AW-1:0]   dec_wr_addr;
   logic [AW-1:0]   dec_rd_addr;
   logic            dec_up, dec_down, dec_read;

   logic            accept;
   logic            slot_free;
   logic            is_full, is_empty;
   logic            up_last, down_last;

   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign up_last   = (idx_ff == pos_ff);
   assign down_last = (CW'(idx_ff) == count_ff);  // count already lowered by one

   iiea_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // request decode: full and empty checks come before the position check
   always_comb begin
      dec_op      = op_type'(req.operation);
      dec_status  = STATUS_DONE;
      dec_count   = count_ff;
      dec_write   = 1'b0;
      dec_wr_addr = AW'(req.position);
      dec_rd_addr = AW'(req.position);
      dec_up      = 1'b0;
      dec_down    = 1'b0;
      dec_read    = 1'b0;
      unique case (dec_op)
         OP_APPEND: begin
            if (is_full) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_write   = 1'b1;
               dec_wr_addr = AW'(count_ff);
               dec_count   = count_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (is_full) begin
               dec_status = STATUS_FULL;
            end else if (req.position > count_ff) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_count = count_ff + 1'b1;
               if (req.position == count_ff) begin
                  // insert at the end needs no move
                  dec_write = 1'b1;
               end else begin
                  // start the move at the top entry
                  dec_up      = 1'b1;
                  dec_rd_addr = AW'(count_ff - 1'b1);
               end
            end
         end
         OP_REMOVE_LAST: begin
            if (is_empty) begin
               dec_status = STATUS_EMPTY;
            end else begin
               dec_count = count_ff - 1'b1;
            end
         end
         OP_REMOVE_AT: begin
            if (is_empty) begin
               dec_status = STATUS_EMPTY;
            end else if (req.position >= count_ff) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_count = count_ff - 1'b1;
               if (req.position != count_ff - 1'b1) begin
                  // start the move at the entry above the hole
                  dec_down    = 1'b1;
                  dec_rd_addr = AW'(req.position + 1'b1);
               end
            end
         end
         OP_READ: begin
            if (is_empty) begin
               dec_status = STATUS_EMPTY;
            end else if (req.position >= count_ff) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_read = 1'b1;
            end
         end
         default: begin
            // unknown code: no change, status done
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (dec_up) begin
                  state_in = ST_SHIFT_UP;
               end else if (dec_down) begin
                  state_in = ST_SHIFT_DOWN;
               end else if (dec_read) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_SHIFT_UP: begin
            if (up_last) begin
               state_in = ST_INS_WRITE;
            end
         end
         ST_INS_WRITE: begin
            state_in = ST_REPLY;
         end
         ST_SHIFT_DOWN: begin
            if (down_last) begin
               state_in = ST_REPLY;
            end
         end
         ST_READ: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and ram control
   always_comb begin
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff;
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      word_in        = word_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_value_in   = rsp_value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in         = AW'(req.position);
               word_in        = req.entry_value;
               count_in       = dec_count;
               pend_status_in = dec_status;
               pend_value_in  = '0;
               ram_wr_en      = dec_write;
               ram_wr_addr    = dec_wr_addr;
               ram_wr_data    = req.entry_value;
               ram_rd_en      = dec_up || dec_down || dec_read;
               ram_rd_addr    = dec_rd_addr;
               idx_in         = dec_rd_addr;
            end
         end
         ST_SHIFT_UP: begin
            // entry fetched last cycle moves one place up
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff + 1'b1;
            if (!up_last) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff - 1'b1;
               idx_in      = idx_ff - 1'b1;
            end
         end
         ST_INS_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = word_ff;
         end
         ST_SHIFT_DOWN: begin
            // entry fetched last cycle moves one place down
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff - 1'b1;
            if (!down_last) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
         end
         ST_READ: begin
            pend_value_in = ram_rd_data;
         end
         ST_REPLY: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_count_in  = count_ff;
               rsp_value_in  = pend_value_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      word_ff        <= word_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_value_ff   <= rsp_value_in;
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.item_count = rsp_count_ff;
   assign rsp.read_value = rsp_value_ff;

   // checks
   `IIEA_ASSERT_DIS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count above depth")
   `IIEA_ASSERT_DIS(a_empty_count, clock, reset,
      rsp_valid_ff && rsp_status_ff == STATUS_EMPTY |-> rsp_count_ff == '0,
      "empty status with nonzero count")
   `IIEA_ASSERT_DIS(a_value_zero, clock, reset,
      rsp_valid_ff && rsp_status_ff != STATUS_DONE |-> rsp_value_ff == '0,
      "read word set on a failed operation")
   `IIEA_ASSERT_DIS(a_accept_busy, clock, reset, accept |=> state_ff != ST_IDLE,
      "sequencer idle right after an accepted transaction")
   `IIEA_ASSERT_DIS(a_down_bound, clock, reset,
      state_ff == ST_SHIFT_DOWN |-> CW'(idx_ff) <= count_ff,
      "move down ran past the list end")

endmodule
